// ===== hw/rtl/plsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plsq_pkg
// Shared types, constants and helper functions of the nine-lane step
// sequencer.
// ----------------------------------------------------------------------------
package plsq_pkg;

	localparam int NUM_LANES  = 9;
	localparam int LANE_STEPS = 16;
	localparam int POS_W      = $clog2(LANE_STEPS);
	localparam int LEN_W      = $clog2(LANE_STEPS + 1);
	localparam int MEM_DEPTH  = NUM_LANES * LANE_STEPS;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);

	localparam int DIV_W      = 32;
	localparam int DIVISOR_W  = 7;
	localparam int DIV_CNT_W  = 6;

	// request modes
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_WRITE  = 3'd1;
	localparam logic [2:0] MODE_LENDIR = 3'd2;
	localparam logic [2:0] MODE_RSTPOS = 3'd3;
	localparam logic [2:0] MODE_SEED   = 3'd4;

	// lane numbers
	localparam logic [3:0] LANE_TRIG   = 4'd0;
	localparam logic [3:0] LANE_PITCH  = 4'd1;
	localparam logic [3:0] LANE_INTV   = 4'd2;
	localparam logic [3:0] LANE_VEL    = 4'd3;
	localparam logic [3:0] LANE_OCT    = 4'd4;
	localparam logic [3:0] LANE_GATE   = 4'd5;
	localparam logic [3:0] LANE_RETRIG = 4'd6;
	localparam logic [3:0] LANE_PROB   = 4'd7;
	localparam logic [3:0] LANE_GLIDE  = 4'd8;

	// directions
	localparam logic [1:0] DIR_REV      = 2'd1;
	localparam logic [1:0] DIR_PINGPONG = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_SCALE_SIZE    = 3'd0;
	localparam logic [2:0] CFG_SCALE_OFFSETS = 3'd1;
	localparam logic [2:0] CFG_MAX_INTERVAL  = 3'd2;
	localparam logic [2:0] CFG_DEF_VELOCITY  = 3'd3;
	localparam logic [2:0] CFG_DEF_GATE      = 3'd4;

	localparam logic [15:0] DEFAULT_PITCH = 16'd60;
	localparam logic [6:0]  NOTE_MAX      = 7'd127;
	localparam logic [7:0]  PERCENT       = 8'd100;
	localparam logic [3:0]  SCALE_MAX     = 4'd12;

	// x / 100 == (x * PERCENT_RECIP) >> PERCENT_SHIFT for every 32-bit x
	localparam logic [31:0] PERCENT_RECIP = 32'h51EB_851F;
	localparam int          PERCENT_SHIFT = 37;
	localparam int          PERCENT_QW    = 26;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CAP,
		ST_DEG,
		ST_DEG_WAIT,
		ST_NOTE,
		ST_RND,
		ST_RND_WAIT,
		ST_DONE
	} plsq_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_W-1:0]     quo;
		logic [DIVISOR_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             bounce;
	} lane_pos_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] s_in);
		logic [31:0] s;
		s = s_in;
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

	function automatic lane_pos_t lane_step(input logic [LEN_W-1:0] len,
		input logic [1:0] dir, input logic [POS_W-1:0] pos, input logic bounce);
		lane_pos_t        r;
		logic [LEN_W-1:0] p;
		p = LEN_W'(pos);
		r.pos = pos;
		r.bounce = bounce;
		if (len > LEN_W'(1)) begin
			if (dir == DIR_REV) begin
				r.pos = (p == '0) ? POS_W'(len - LEN_W'(1)) : POS_W'(p - LEN_W'(1));
			end else if (dir == DIR_PINGPONG) begin
				if (!bounce) begin
					if (p >= len - LEN_W'(1)) begin
						r.bounce = 1'b1;
						r.pos = POS_W'(p - LEN_W'(1));
					end else begin
						r.pos = POS_W'(p + LEN_W'(1));
					end
				end else begin
					if (p == '0) begin
						r.bounce = 1'b0;
						r.pos = POS_W'(1);
					end else begin
						r.pos = POS_W'(p - LEN_W'(1));
					end
				end
			end else begin
				r.pos = (p + LEN_W'(1) >= len) ? '0 : POS_W'(p + LEN_W'(1));
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/plsq_lane_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plsq_lane_mem
// Lane step store: one write port, one registered read port, and a valid
// bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module plsq_lane_mem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [plsq_pkg::MEM_AW-1:0] wr_addr,
	input  wire logic [15:0]               wr_data,
	input  wire logic [plsq_pkg::MEM_AW-1:0] rd_addr,
	output logic      [15:0]               rd_data
);
	import plsq_pkg::*;

	logic [15:0]          mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	logic [15:0]          rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/plsq_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plsq_div
// Bit-serial restoring divider, one quotient bit per cycle.
// The dividend is taken MSB first; run 'steps' iterations.
// ----------------------------------------------------------------------------
module plsq_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire plsq_pkg::div_req_t req,
	output plsq_pkg::div_rsp_t      rsp
);
	import plsq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [DIVISOR_W:0]   trial;
	logic                 take;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		take  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], take};
			rem_q <= take ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

// ===== hw/rtl/polymetric_lane_step_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polymetric_lane_step_sequencer
// Nine-lane polymetric step sequencer with scale mapping and probability.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns exactly one result per request.
// Write, length/direction, position-reset, seed and unknown requests go
// from idle straight to the done state. A tick that does not fire reads only
// the trigger lane. A firing tick reads the nine lanes one after another
// through the single read port of the lane store (a read and a capture state
// per lane), sets up the scale degree, runs the bit-serial divider (8
// quotient bits, skipped for a chromatic scale or an empty interval lane),
// registers the note, derives the random percent by reciprocal
// multiplication (only when the probability step is below 100) and hands
// off the result from the done state. The result sits in an output
// register, so a new request is taken as soon as the sequencer returns to
// idle, even if the last result has not yet been taken; a second result
// waits in the done state until the output register frees up. The lane
// store clears through per-entry valid bits at reset, so no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module polymetric_lane_step_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [3:0]  lane,
	input  wire logic [3:0]  slot,
	input  wire logic signed [15:0] value,
	input  wire logic [4:0]  length,
	input  wire logic [1:0]  direction,
	input  wire logic [31:0] seed,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             fired,
	output logic [6:0]       note,
	output logic [7:0]       velocity,
	output logic [7:0]       gate_length,
	output logic [7:0]       retrigger_count,
	output logic             glide_on
);
	import plsq_pkg::*;

	// configuration
	logic [3:0]  scale_size_q;
	logic [47:0] scale_offsets_q;
	logic [6:0]  max_interval_q;
	logic [7:0]  def_velocity_q;
	logic [7:0]  def_gate_q;

	// lane control
	logic [LEN_W-1:0] len_q    [NUM_LANES];
	logic [1:0]       dir_q    [NUM_LANES];
	logic [POS_W-1:0] pos_q    [NUM_LANES];
	logic             bounce_q [NUM_LANES];

	plsq_state_t state_q, state_d;

	logic              accept;
	logic              out_load;
	logic [3:0]        cur_q;
	logic              fire_q;
	logic              drop_q;
	logic signed [15:0] pitch_q;
	logic signed [7:0] acc_q;
	logic              use_int_q;
	logic [7:0]        vel_q;
	logic signed [15:0] oct_q;
	logic [7:0]        gate_q;
	logic [7:0]        retrig_q;
	logic              use_prob_q;
	logic [7:0]        prob_q;
	logic              glide_q;
	logic signed [11:0] semis_q;
	logic [6:0]        note_q;
	logic [31:0]       rand_q;
	logic [PERCENT_QW-1:0] rnd_quo_q;

	// output register
	logic       out_valid_q;
	logic       fired_q;
	logic [6:0] note_o_q;
	logic [7:0] vel_o_q;
	logic [7:0] gate_o_q;
	logic [7:0] retrig_o_q;
	logic       glide_o_q;

	// lane store
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [MEM_AW-1:0] mem_raddr;
	logic [15:0]       mem_rdata;
	logic [15:0]       lane_val;
	logic              lane_live;
	lane_pos_t         adv;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// datapath helpers
	logic [3:0]         scale_n;
	logic               chromatic;
	logic signed [16:0] acc_sum;
	logic signed [16:0] lim_pos;
	logic signed [16:0] lim_neg;
	logic signed [7:0]  acc_next;
	logic [7:0]         acc_abs;
	logic [31:0]        rand_next;
	logic [63:0]        rnd_prod;
	logic [31:0]        rnd_rem;
	logic [7:0]         deg_q8;
	logic [3:0]         deg_r4;
	logic signed [7:0]  deg_oct;
	logic [3:0]         deg_rem;
	logic [3:0]         deg_ofs;
	logic signed [11:0] deg_semis;
	logic signed [21:0] oct_ext;
	logic signed [21:0] note_sum;
	logic [6:0]         note_clamp;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Store writes happen only on accepted write requests in idle; read data is
	// used only while walking the lanes of a tick, so the two ports never collide.
	assign mem_we    = accept && mode == MODE_WRITE && 32'(lane) < NUM_LANES
		&& 32'(slot) < LANE_STEPS;
	assign mem_waddr = MEM_AW'(32'(lane) * LANE_STEPS + 32'(slot));
	assign mem_raddr = MEM_AW'(32'(cur_q) * LANE_STEPS + 32'(pos_q[cur_q]));

	plsq_lane_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (value),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	plsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		// an empty lane reads as zero
		lane_live = len_q[cur_q] != '0;
		lane_val  = lane_live ? mem_rdata : '0;
		adv       = lane_step(len_q[cur_q], dir_q[cur_q], pos_q[cur_q], bounce_q[cur_q]);

		scale_n   = (scale_size_q > SCALE_MAX) ? SCALE_MAX : scale_size_q;
		chromatic = scale_n <= 4'd1;

		// interval accumulation, clamped to +/- max_interval
		acc_sum  = $signed({{9{acc_q[7]}}, acc_q}) + $signed({lane_val[15], lane_val});
		lim_pos  = $signed({10'd0, max_interval_q});
		lim_neg  = -lim_pos;
		if (acc_sum > lim_pos) begin
			acc_next = lim_pos[7:0];
		end else if (acc_sum < lim_neg) begin
			acc_next = lim_neg[7:0];
		end else begin
			acc_next = acc_sum[7:0];
		end
		acc_abs = acc_q[7] ? 8'(-acc_q) : 8'(acc_q);

		// floored division result: a negative degree with a remainder
		// rounds the octave down and folds the remainder back up
		deg_q8 = div_rsp.quo[7:0];
		deg_r4 = div_rsp.rem[3:0];
		if (acc_q[7]) begin
			deg_oct = (deg_r4 != '0) ? $signed(~deg_q8) : $signed(-deg_q8);
			deg_rem = (deg_r4 != '0) ? scale_n - deg_r4 : '0;
		end else begin
			deg_oct = $signed(deg_q8);
			deg_rem = deg_r4;
		end
		deg_ofs   = (deg_rem != '0) ? scale_offsets_q[{deg_rem, 2'b00} +: 4] : '0;
		deg_semis = ($signed({{4{deg_oct[7]}}, deg_oct}) <<< 3)
			+ ($signed({{4{deg_oct[7]}}, deg_oct}) <<< 2)
			+ $signed({8'd0, deg_ofs});

		oct_ext  = $signed({{6{oct_q[15]}}, oct_q});
		note_sum = $signed({{6{pitch_q[15]}}, pitch_q})
			+ $signed({{10{semis_q[11]}}, semis_q})
			+ (oct_ext <<< 3) + (oct_ext <<< 2);
		if (note_sum < 0) begin
			note_clamp = '0;
		end else if (note_sum > $signed({15'd0, NOTE_MAX})) begin
			note_clamp = NOTE_MAX;
		end else begin
			note_clamp = note_sum[6:0];
		end

		// random percent: quotient by reciprocal multiply, then remainder
		rand_next = xorshift32(rand_q);
		rnd_prod  = {32'd0, rand_next} * {32'd0, PERCENT_RECIP};
		rnd_rem   = rand_q - 32'(rnd_quo_q) * 32'(PERCENT);
	end

	// --- sequencer --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		div_req.start    = 1'b0;
		div_req.steps    = DIV_CNT_W'(8);
		div_req.dividend = {acc_abs, 24'd0};
		div_req.divisor  = DIVISOR_W'(scale_n);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (mode == MODE_TICK) ? ST_RD : ST_DONE;
				end
			end
			ST_RD: begin
				state_d = ST_CAP;
			end
			ST_CAP: begin
				if (cur_q == LANE_TRIG) begin
					state_d = (len_q[cur_q] != '0 && lane_val != '0) ? ST_RD : ST_DONE;
				end else if (cur_q == LANE_GLIDE) begin
					state_d = ST_DEG;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_DEG: begin
				if (use_int_q && !chromatic) begin
					div_req.start = 1'b1;
					state_d = ST_DEG_WAIT;
				end else begin
					state_d = ST_NOTE;
				end
			end
			ST_DEG_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_NOTE;
				end
			end
			ST_NOTE: begin
				state_d = use_prob_q ? ST_RND : ST_DONE;
			end
			ST_RND: begin
				state_d = ST_RND_WAIT;
			end
			ST_RND_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// --- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_size_q    <= 4'd7;
			scale_offsets_q <= '0;
			max_interval_q  <= 7'd48;
			def_velocity_q  <= 8'd100;
			def_gate_q      <= 8'd50;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SCALE_SIZE:    scale_size_q    <= cfg_data[3:0];
				CFG_SCALE_OFFSETS: scale_offsets_q <= cfg_data;
				CFG_MAX_INTERVAL:  max_interval_q  <= cfg_data[6:0];
				CFG_DEF_VELOCITY:  def_velocity_q  <= cfg_data[7:0];
				CFG_DEF_GATE:      def_gate_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// --- lane length, direction and position --------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				len_q[i]    <= '0;
				dir_q[i]    <= '0;
				pos_q[i]    <= '0;
				bounce_q[i] <= 1'b0;
			end
		end else if (accept && mode == MODE_LENDIR && 32'(lane) < NUM_LANES) begin
			// saturate the length; drop a position that falls outside it
			if (32'(length) > LANE_STEPS) begin
				len_q[lane] <= LEN_W'(LANE_STEPS);
				if (LEN_W'(pos_q[lane]) >= LEN_W'(LANE_STEPS)) begin
					pos_q[lane]    <= '0;
					bounce_q[lane] <= 1'b0;
				end
			end else begin
				len_q[lane] <= LEN_W'(length);
				if (32'(pos_q[lane]) >= 32'(length)) begin
					pos_q[lane]    <= '0;
					bounce_q[lane] <= 1'b0;
				end
			end
			dir_q[lane] <= direction;
		end else if (accept && mode == MODE_RSTPOS) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				pos_q[i]    <= '0;
				bounce_q[i] <= 1'b0;
			end
		end else if (state_q == ST_CAP) begin
			// the trigger lane always advances; others only on a fired tick
			pos_q[cur_q]    <= adv.pos;
			bounce_q[cur_q] <= adv.bounce;
		end
	end

	// --- tick datapath ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= LANE_TRIG;
			fire_q     <= 1'b0;
			drop_q     <= 1'b0;
			acc_q      <= '0;
			rand_q     <= 32'd1;
			rnd_quo_q  <= '0;
			use_int_q  <= 1'b0;
			use_prob_q <= 1'b0;
			pitch_q    <= '0;
			vel_q      <= '0;
			oct_q      <= '0;
			gate_q     <= '0;
			retrig_q   <= '0;
			prob_q     <= '0;
			glide_q    <= 1'b0;
			semis_q    <= '0;
			note_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q  <= LANE_TRIG;
						fire_q <= 1'b0;
						drop_q <= 1'b0;
						if (mode == MODE_RSTPOS) begin
							acc_q <= '0;
						end
						if (mode == MODE_SEED) begin
							rand_q <= (seed == '0) ? 32'd1 : seed;
						end
					end
				end
				ST_CAP: begin
					cur_q <= cur_q + 4'd1;
					case (cur_q)
						LANE_TRIG:   fire_q <= lane_live && lane_val != '0;
						LANE_PITCH:  pitch_q <= lane_live ? $signed(lane_val)
							: $signed(DEFAULT_PITCH);
						LANE_INTV: begin
							use_int_q <= lane_live;
							if (lane_live) begin
								acc_q <= acc_next;
							end
						end
						LANE_VEL:    vel_q <= lane_live ? lane_val[7:0] : def_velocity_q;
						LANE_OCT:    oct_q <= $signed(lane_val);
						LANE_GATE:   gate_q <= lane_live ? lane_val[7:0] : def_gate_q;
						LANE_RETRIG: retrig_q <= lane_val[7:0];
						LANE_PROB: begin
							use_prob_q <= lane_live && lane_val[7:0] < PERCENT;
							prob_q     <= lane_val[7:0];
						end
						LANE_GLIDE:  glide_q <= lane_val != '0;
						default: ;
					endcase
				end
				ST_DEG: begin
					// chromatic scale passes degrees straight through
					semis_q <= use_int_q ? 12'($signed(acc_q)) : '0;
				end
				ST_DEG_WAIT: begin
					if (div_rsp.done) begin
						semis_q <= deg_semis;
					end
				end
				ST_NOTE: begin
					note_q <= note_clamp;
				end
				ST_RND: begin
					// advance the generator and hold the quotient by 100
					rand_q    <= rand_next;
					rnd_quo_q <= rnd_prod[PERCENT_SHIFT +: PERCENT_QW];
				end
				ST_RND_WAIT: begin
					drop_q <= rnd_rem[7:0] >= prob_q;
				end
				default: ;
			endcase
		end
	end

	// --- output register ----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// rests, drops and non-tick requests report all zeros
			fired_q    <= fire_q && !drop_q;
			note_o_q   <= (fire_q && !drop_q) ? note_q : '0;
			vel_o_q    <= (fire_q && !drop_q) ? vel_q : '0;
			gate_o_q   <= (fire_q && !drop_q) ? gate_q : '0;
			retrig_o_q <= (fire_q && !drop_q) ? retrig_q : '0;
			glide_o_q  <= fire_q && !drop_q && glide_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign fired           = fired_q;
	assign note            = note_o_q;
	assign velocity        = vel_o_q;
	assign gate_length     = gate_o_q;
	assign retrigger_count = retrig_o_q;
	assign glide_on        = glide_o_q;

`ifndef SYNTH
	a_rest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> note == '0 && velocity == '0 && gate_length == '0
			&& retrigger_count == '0 && !glide_on)
		else $error("rest result carries nonzero fields");

	a_rand_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rand_q != '0)
		else $error("random state reached zero");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DEG_WAIT || state_q == ST_RND_WAIT)
		else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire

// ===== dv/polymetric_lane_step_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// polymetric_lane_step_sequencer_test
// Self-checking bench for the nine-lane step sequencer: drives requests with
// random gaps against a random output stall, predicts every result with an
// in-bench model of the lanes, scale mapping and probability generator, and
// compares every field of each result in order.
// ----------------------------------------------------------------------------
module polymetric_lane_step_sequencer_test;
	import plsq_pkg::*;

	localparam logic [1:0] DIR_FWD      = 2'd0;
	localparam logic [1:0] DIR_THREE    = 2'd3;
	localparam int         IDLE_LIMIT   = 5000;
	localparam int         MAX_REPORTS  = 10;
	localparam int         RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic       fired;
		logic [6:0] note;
		logic [7:0] velocity;
		logic [7:0] gate_length;
		logic [7:0] retrigger_count;
		logic       glide_on;
	} step_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  mode;
	logic [3:0]  lane;
	logic [3:0]  slot;
	logic signed [15:0] value;
	logic [4:0]  length;
	logic [1:0]  direction;
	logic [31:0] seed;
	logic        out_valid;
	logic        out_stall;
	logic        fired;
	logic [6:0]  note;
	logic [7:0]  velocity;
	logic [7:0]  gate_length;
	logic [7:0]  retrigger_count;
	logic        glide_on;

	polymetric_lane_step_sequencer dut (.*);

	// Shadow copy of the sequencer: registers and lane state.
	logic [3:0]         sh_scale_size;
	logic [47:0]        sh_scale_offsets;
	logic [6:0]         sh_max_interval;
	logic [7:0]         sh_def_velocity;
	logic [7:0]         sh_def_gate;
	logic signed [15:0] sh_steps [NUM_LANES][LANE_STEPS];
	logic [4:0]         sh_len [NUM_LANES];
	logic [1:0]         sh_dir [NUM_LANES];
	logic [3:0]         sh_pos [NUM_LANES];
	logic               sh_bounce [NUM_LANES];
	int                 sh_degrees;
	logic [31:0]        sh_rng;

	step_result_t pending_notes[$];
	int           mismatches;
	int           idle_cycles;
	bit           quiet_phase;   // no idling on either side while set

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int step_value(int l);
		if (sh_len[l] == 0) return 0;
		return int'(sh_steps[l][sh_pos[l]]);
	endfunction

	// Move one lane a step along its direction; direction three acts as forward.
	function automatic void lane_move(int l);
		int n;
		int p;
		n = sh_len[l];
		p = sh_pos[l];
		if (n <= 1) return;
		if (sh_dir[l] == DIR_REV) begin
			sh_pos[l] = (p == 0) ? 4'(n - 1) : 4'(p - 1);
		end else if (sh_dir[l] == DIR_PINGPONG) begin
			if (!sh_bounce[l]) begin
				if (p >= n - 1) begin
					sh_bounce[l] = 1'b1;
					sh_pos[l] = 4'(p - 1);
				end else begin
					sh_pos[l] = 4'(p + 1);
				end
			end else if (p == 0) begin
				sh_bounce[l] = 1'b0;
				sh_pos[l] = 4'd1;
			end else begin
				sh_pos[l] = 4'(p - 1);
			end
		end else begin
			sh_pos[l] = 4'((p + 1) % n);
		end
	endfunction

	function automatic void move_note_lanes();
		for (int l = 1; l < NUM_LANES; l++) lane_move(l);
	endfunction

	// Floored division of the degree by the scale size; remainder picks a nibble.
	function automatic int degree_semitones(int deg);
		int sz;
		int oct;
		int rem;
		sz = (sh_scale_size > 12) ? 12 : int'(sh_scale_size);
		if (sz <= 1) return deg;
		oct = (deg >= 0) ? deg / sz : (deg - sz + 1) / sz;
		rem = deg - oct * sz;
		if (rem > 0) return oct * 12 + int'(sh_scale_offsets[4 * rem +: 4]);
		return oct * 12;
	endfunction

	function automatic void clear_positions();
		for (int l = 0; l < NUM_LANES; l++) begin
			sh_pos[l] = '0;
			sh_bounce[l] = 1'b0;
		end
		sh_degrees = 0;
	endfunction

	function automatic void shadow_reset();
		sh_scale_size = 4'd7;
		sh_scale_offsets = '0;
		sh_max_interval = 7'd48;
		sh_def_velocity = 8'd100;
		sh_def_gate = 8'd50;
		for (int l = 0; l < NUM_LANES; l++) begin
			sh_len[l] = '0;
			sh_dir[l] = DIR_FWD;
			for (int s = 0; s < LANE_STEPS; s++) sh_steps[l][s] = '0;
		end
		clear_positions();
		sh_rng = 32'd1;
	endfunction

	// Work out the result of one accepted request and update the shadow state.
	function automatic step_result_t play_step(logic [2:0] m, logic [3:0] ln,
		logic [3:0] sl, logic signed [15:0] v, logic [4:0] len, logic [1:0] dir,
		logic [31:0] sd);
		step_result_t r;
		int           pitch;
		int           lim;
		int           prob;
		logic         hit;
		r = '0;
		case (m)
			MODE_WRITE: begin
				if (ln < NUM_LANES) sh_steps[ln][sl] = v;
			end
			MODE_LENDIR: begin
				if (ln < NUM_LANES) begin
					sh_len[ln] = (len > LANE_STEPS) ? 5'(LANE_STEPS) : len;
					sh_dir[ln] = dir;
					if (sh_pos[ln] >= sh_len[ln]) begin
						sh_pos[ln] = '0;
						sh_bounce[ln] = 1'b0;
					end
				end
			end
			MODE_RSTPOS: clear_positions();
			MODE_SEED:   sh_rng = (sd == 0) ? 32'd1 : sd;
			MODE_TICK: begin
				hit = (sh_len[LANE_TRIG] > 0) && (step_value(LANE_TRIG) != 0);
				lane_move(LANE_TRIG);
				if (!hit) return r;
				pitch = (sh_len[LANE_PITCH] > 0) ? step_value(LANE_PITCH) : 60;
				if (sh_len[LANE_INTV] > 0) begin
					lim = sh_max_interval;
					sh_degrees += step_value(LANE_INTV);
					if (sh_degrees > lim) sh_degrees = lim;
					if (sh_degrees < -lim) sh_degrees = -lim;
					pitch += degree_semitones(sh_degrees);
				end
				if (sh_len[LANE_OCT] > 0) pitch += step_value(LANE_OCT) * 12;
				if (pitch < 0) pitch = 0;
				if (pitch > 127) pitch = 127;
				if (sh_len[LANE_PROB] > 0) begin
					prob = step_value(LANE_PROB) & 8'hFF;
					if (prob < 100) begin
						sh_rng ^= sh_rng << 13;
						sh_rng ^= sh_rng >> 17;
						sh_rng ^= sh_rng << 5;
						if (sh_rng % 100 >= prob) begin
							move_note_lanes();
							return r;
						end
					end
				end
				r.fired = 1'b1;
				r.note = 7'(pitch);
				r.velocity = (sh_len[LANE_VEL] > 0) ? 8'(step_value(LANE_VEL)) : sh_def_velocity;
				r.gate_length = (sh_len[LANE_GATE] > 0) ? 8'(step_value(LANE_GATE)) : sh_def_gate;
				r.retrigger_count = (sh_len[LANE_RETRIG] > 0) ? 8'(step_value(LANE_RETRIG)) : 8'd0;
				r.glide_on = (sh_len[LANE_GLIDE] > 0) && (step_value(LANE_GLIDE) != 0);
				move_note_lanes();
			end
			default: ;   // unknown modes change nothing
		endcase
		return r;
	endfunction

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Request side: hold the request until it is taken, then maybe idle.
	// ------------------------------------------------------------------------
	task automatic send_request(logic [2:0] m, logic [3:0] ln, logic [3:0] sl,
		logic signed [15:0] v, logic [4:0] len, logic [1:0] dir, logic [31:0] sd);
		int gap;
		in_valid  <= 1'b1;
		mode      <= m;
		lane      <= ln;
		slot      <= sl;
		value     <= v;
		length    <= len;
		direction <= dir;
		seed      <= sd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_notes.push_back(play_step(m, ln, sl, v, len, dir, sd));
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_notes.size() != 0) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(logic [2:0] idx, logic [47:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_SCALE_SIZE:    sh_scale_size = data[3:0];
			CFG_SCALE_OFFSETS: sh_scale_offsets = data;
			CFG_MAX_INTERVAL:  sh_max_interval = data[6:0];
			CFG_DEF_VELOCITY:  sh_def_velocity = data[7:0];
			CFG_DEF_GATE:      sh_def_gate = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_all_regs(logic [3:0] sz, logic [47:0] offs, logic [6:0] mi,
		logic [7:0] vel, logic [7:0] gt);
		drain();
		write_reg(CFG_SCALE_SIZE, 48'(sz));
		write_reg(CFG_SCALE_OFFSETS, offs);
		write_reg(CFG_MAX_INTERVAL, 48'(mi));
		write_reg(CFG_DEF_VELOCITY, 48'(vel));
		write_reg(CFG_DEF_GATE, 48'(gt));
		cfg_wen <= 1'b0;
	endtask

	task automatic write_step(logic [3:0] ln, logic [3:0] sl, logic signed [15:0] v);
		send_request(MODE_WRITE, ln, sl, v, 5'($urandom), 2'($urandom), $urandom);
	endtask

	task automatic set_lane(logic [3:0] ln, logic [4:0] len, logic [1:0] dir);
		send_request(MODE_LENDIR, ln, 4'($urandom), 16'($urandom), len, dir, $urandom);
	endtask

	task automatic tick();
		send_request(MODE_TICK, 4'($urandom), 4'($urandom), 16'($urandom),
			5'($urandom), 2'($urandom), $urandom);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty lanes: ticks rest, unknown modes and out-of-range lanes do nothing.
	task automatic test_empty_lanes();
		tick();
		send_request(3'd5, 4'd15, 4'd15, 16'sh7FFF, 5'd31, 2'd3, '1);
		send_request(3'd7, 4'd0, 4'd0, -16'sd32768, 5'd0, 2'd0, '0);
		write_step(4'd9, 4'd0, 16'sd1);
		set_lane(4'd15, 5'd16, DIR_FWD);
		tick();
	endtask

	// Single-step trigger with defaults, then extreme values and saturations.
	task automatic test_directed_notes();
		write_step(LANE_TRIG, 4'd0, 16'sd1);
		set_lane(LANE_TRIG, 5'd1, DIR_FWD);
		tick();                                      // default pitch, velocity, gate
		write_step(LANE_PITCH, 4'd0, 16'sh7FFF);
		set_lane(LANE_PITCH, 5'd31, DIR_THREE);      // long length saturates
		write_step(LANE_VEL, 4'd0, -16'sd1);
		set_lane(LANE_VEL, 5'd1, DIR_REV);
		write_step(LANE_GLIDE, 4'd0, -16'sd32768);
		set_lane(LANE_GLIDE, 5'd1, DIR_PINGPONG);
		tick();                                      // pitch clamps high
		write_step(LANE_OCT, 4'd0, -16'sd32768);
		set_lane(LANE_OCT, 5'd1, DIR_FWD);
		tick();                                      // note clamps low
		write_step(LANE_PROB, 4'd0, 16'sd0);
		set_lane(LANE_PROB, 5'd1, DIR_FWD);
		send_request(MODE_SEED, '0, '0, '0, '0, '0, 32'd0);   // zero seed
		tick();                                      // probability zero never plays
		set_lane(LANE_PITCH, 5'd0, DIR_FWD);         // stale position cleared
		send_request(MODE_RSTPOS, '1, '1, '1, '1, '1, '1);
		tick();
	endtask

	// One random request: a tick, step write, lane setup, position reset, seed or unknown mode.
	task automatic random_item();
		int r;
		logic signed [15:0] v;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: v = 16'($urandom);
			1: v = 16'($signed($urandom_range(0, 16)) - 8);
			2: v = 16'($urandom_range(0, 150));
			default: v = 16'($urandom_range(0, 1));
		endcase
		if (r < 45) begin
			tick();
		end else if (r < 70) begin
			send_request(MODE_WRITE,
				($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
				4'($urandom), v, 5'($urandom), 2'($urandom), $urandom);
		end else if (r < 85) begin
			send_request(MODE_LENDIR,
				($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
				4'($urandom), 16'($urandom),
				($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16)),
				2'($urandom), $urandom);
		end else if (r < 90) begin
			send_request(MODE_RSTPOS, 4'($urandom), 4'($urandom), 16'($urandom),
				5'($urandom), 2'($urandom), $urandom);
		end else if (r < 95) begin
			send_request(MODE_SEED, 4'($urandom), 4'($urandom), 16'($urandom),
				5'($urandom), 2'($urandom), ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
		end else begin
			send_request(3'($urandom_range(MODE_SEED + 1, 7)), 4'($urandom),
				4'($urandom), 16'($urandom), 5'($urandom), 2'($urandom), $urandom);
		end
	endtask

	task automatic test_random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
			random_item();
		end
		quiet_phase = 1'b0;
	endtask

	// Sweep register settings, extremes included, with random traffic.
	task automatic test_register_sweep();
		set_all_regs(4'd0, 48'h0, 7'd0, 8'd0, 8'd0);
		test_random_phase(RANDOM_ITEMS / 5);
		set_all_regs(4'd15, '1, 7'd127, 8'd255, 8'd255);
		test_random_phase(RANDOM_ITEMS / 5);
		set_all_regs(4'd1, 48'h0, 7'd127, 8'd1, 8'd2);
		test_random_phase(RANDOM_ITEMS / 5);
		set_all_regs(4'd7, 48'hBA9_8754_3210 & 48'hFFFF_FFFF_FFFF, 7'd48, 8'd100, 8'd50);
		test_random_phase(RANDOM_ITEMS / 5);
		set_all_regs(4'($urandom_range(2, 12)), {$urandom, 16'($urandom)},
			7'($urandom), 8'($urandom), 8'($urandom));
		test_random_phase(RANDOM_ITEMS / 5);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall, check of every field against the oldest note.
	// ------------------------------------------------------------------------
	initial begin
		int run;
		forever begin
			run = pick_gap();
			out_stall <= (run > 0);
			repeat ((run > 0) ? run : $urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		step_result_t exp_r;
		step_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{fired, note, velocity, gate_length, retrigger_count, glide_on};
			if (pending_notes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result %p", got);
			end else begin
				exp_r = pending_notes.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
	end

	// Watchdog: give up when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatches = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = '0;
		lane = '0;
		slot = '0;
		value = '0;
		length = '0;
		direction = '0;
		seed = '0;
		shadow_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_lanes();
		test_directed_notes();
		test_register_sweep();
		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_notes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
